// ===== rtl/core/erc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// erc_pkg: shared definitions for the event rate and roughness counter
// Field widths, operation codes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ============================================================================

package erc_pkg;

    // Fixed field widths of the channels.
    localparam int FUNC_W  = 3;
    localparam int DELTA_W = 32;
    localparam int VAL_W   = 64;
    localparam int OUT_W   = 48;

    // Defaults for the top-level parameters.
    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // A gap of 2^32 ticks or more squares past 64 bits, so the square
    // multiplier only ever sees the low 32 bits of a gap.
    localparam int SQ_HALF_W = VAL_W / 2;

    // The roughness product is built from four partial products of a
    // squared-gap half by a rate-magnitude half.
    localparam int RM_HALF_W = OUT_W / 2;
    localparam int PROD_W    = SQ_HALF_W + RM_HALF_W;
    localparam int ACC_W     = VAL_W + OUT_W;
    localparam int MUL_STEPS = 4;
    localparam int MUL_IDX_W = $clog2(MUL_STEPS);

    // Divider numerator: twice the roughness product; also holds the
    // scaled rate numerator for up to 49 fraction bits.
    localparam int NUM_W = ACC_W + 1;
    localparam int QUO_W = OUT_W;

    // Operation codes of the input word.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 3'd0,
        FUNC_EVENT      = 3'd1,
        FUNC_READ       = 3'd2,
        FUNC_READ_RESET = 3'd3,
        FUNC_CLEAR      = 3'd4
    } func_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_RATE_DIV,
        ST_MUL_GO,
        ST_MUL,
        ST_ROUGH_DIV,
        ST_LOAD
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic tick_en;
        logic event_en;
        logic clear_en;
        logic div_start;
        logic div_sel_rough;
        logic rate_load;
        logic mul_start;
        logic rough_load;
        logic res_zero;
        logic out_load;
        logic interval_reset;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sq_busy;
        logic elapsed_zero;
        logic div_done;
        logic div_busy;
        logic mul_done;
    } dp_status_t;

endpackage

// ===== rtl/core/erc_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// erc_if: channel interfaces of the event rate and roughness counter
// One interface carries input words (operation and delta), the other
// carries result words (total, rate and roughness).
// ============================================================================

interface erc_in_if;
    import erc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [DELTA_W-1:0] delta;

    modport source (output valid, output func, output delta, input ready);
    modport sink   (input valid, input func, input delta, output ready);
endinterface

interface erc_out_if;
    import erc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] total_value;
    logic signed [OUT_W-1:0] rate_q16;
    logic signed [OUT_W-1:0] roughness_q16;

    modport source (output valid, output total_value, output rate_q16,
                    output roughness_q16, input ready);
    modport sink   (input valid, input total_value, input rate_q16,
                    input roughness_q16, output ready);
endinterface

// ===== rtl/core/erc_div.sv =====
`timescale 1ns / 1ps
// ============================================================================
// erc_div: radix-2 restoring divider with early saturation
// Divides a wide numerator by the elapsed tick count and returns a 48-bit
// quotient, or flags overflow at once when the quotient cannot fit.
// ============================================================================

module erc_div #(
    parameter int TIME_BITS = erc_pkg::TIME_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [erc_pkg::NUM_W-1:0]   num,
    input  logic [TIME_BITS-1:0]        den,
    output logic                        busy,
    output logic                        done,
    output logic [erc_pkg::QUO_W-1:0]   quo,
    output logic                        ovf
);
    import erc_pkg::*;

    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CNT_W = $clog2(QUO_W);

    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] rem_next;
    logic [TIME_BITS-1:0] den_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic [QUO_W-1:0]     quo_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic                 ovf_reg;

    logic [HI_W-1:0]      num_hi;
    logic                 ovf_now;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   trial_diff;
    logic                 trial_ge;

    // The quotient overflows 48 bits exactly when the upper numerator part
    // is not below the divisor.
    assign num_hi  = num[NUM_W-1:QUO_W];
    assign ovf_now = (num_hi >= HI_W'(den));

    // One quotient bit per cycle: shift in the next numerator bit and
    // subtract when the partial remainder allows it.
    assign trial      = {rem_reg, quo_reg[QUO_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next = trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        quo_next = {quo_reg[QUO_W-2:0], trial_ge};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !ovf_now;
            done_reg <= ovf_now;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUO_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Remainder, divisor and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            ovf_reg <= ovf_now;
            rem_reg <= num_hi[TIME_BITS-1:0];
            quo_reg <= num[QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== rtl/core/erc_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// erc_dp: datapath of the event rate and roughness counter
// Holds the tick clock and interval sums, squares event gaps in a short
// pipeline, and forms rate and roughness with a partial-product multiplier
// and the shared divider.
// ============================================================================

module erc_dp #(
    parameter int TIME_BITS = erc_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = erc_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  erc_pkg::dp_cmd_t                    cmd,
    output erc_pkg::dp_status_t                 status,
    input  logic signed [erc_pkg::DELTA_W-1:0]  delta,
    output logic signed [erc_pkg::VAL_W-1:0]    total_value,
    output logic signed [erc_pkg::OUT_W-1:0]    rate_q16,
    output logic signed [erc_pkg::OUT_W-1:0]    roughness_q16
);
    import erc_pkg::*;

    // Architectural state.
    logic [TIME_BITS-1:0] tick_now_reg, tick_now_next;
    logic [TIME_BITS-1:0] begin_reg, begin_next;
    logic [TIME_BITS-1:0] last_event_reg, last_event_next;
    logic [VAL_W-1:0]     base_reg, base_next;
    logic [VAL_W-1:0]     isum_reg, isum_next;
    logic [VAL_W-1:0]     sq_sum_reg, sq_sum_next;

    // Gap-square pipeline.
    logic                 s1_vld_reg, s2_vld_reg;
    logic [SQ_HALF_W-1:0] gap_lo_reg;
    logic                 gap_sat_reg;
    logic [VAL_W-1:0]     sq_reg;
    logic [VAL_W-1:0]     sq_prod;
    logic [VAL_W:0]       sq_acc;
    logic [TIME_BITS-1:0] gap;
    logic [VAL_W-1:0]     gap_ext;
    logic                 event_hit;

    // Read arithmetic.
    logic [TIME_BITS-1:0] elapsed;
    logic                 neg;
    logic [VAL_W-1:0]     smag;
    logic [NUM_W-1:0]     rate_num;
    logic [NUM_W-1:0]     rough_num;
    logic [NUM_W-1:0]     div_num;
    logic [QUO_W-1:0]     div_quo;
    logic                 div_ovf;
    logic                 div_busy;
    logic                 div_done;
    logic [OUT_W-1:0]     lim;
    logic [OUT_W-1:0]     mag_clamped;
    logic [OUT_W-1:0]     enc;
    logic [OUT_W-1:0]     rmag_reg;
    logic [OUT_W-1:0]     rate_reg;
    logic [OUT_W-1:0]     rough_reg;

    // Partial-product multiplier.
    logic                 mul_run_reg;
    logic [MUL_IDX_W-1:0] mul_idx_reg;
    logic                 prod_vld_reg;
    logic [MUL_IDX_W-1:0] prod_idx_reg;
    logic                 mul_done_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [SQ_HALF_W-1:0] mul_a;
    logic [RM_HALF_W-1:0] mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [ACC_W-1:0]     prod_ext;
    logic [ACC_W-1:0]     prod_sh_a;
    logic [ACC_W-1:0]     prod_sh_b;
    logic [ACC_W-1:0]     acc_reg;

    // Output register.
    logic [VAL_W-1:0]     total_out_reg;
    logic [OUT_W-1:0]     rate_out_reg;
    logic [OUT_W-1:0]     rough_out_reg;

    // An event of zero delta leaves everything untouched.
    assign event_hit = cmd.event_en && (delta != '0);

    // Gap since the previous event; anything at or above 2^32 saturates.
    assign gap     = tick_now_reg - last_event_reg;
    assign gap_ext = VAL_W'(gap);
    assign sq_prod = gap_lo_reg * gap_lo_reg;
    assign sq_acc  = {1'b0, sq_sum_reg} + {1'b0, sq_reg};

    // Next state of the counters and sums.
    always_comb
    begin
        tick_now_next   = tick_now_reg;
        begin_next      = begin_reg;
        last_event_next = last_event_reg;
        base_next       = base_reg;
        isum_next       = isum_reg;
        sq_sum_next     = sq_sum_reg;

        if (cmd.tick_en)
        begin
            tick_now_next = tick_now_reg + TIME_BITS'(1);
        end

        if (event_hit)
        begin
            isum_next       = isum_reg + VAL_W'(delta);
            last_event_next = tick_now_reg;
        end

        if (s2_vld_reg)
        begin
            sq_sum_next = sq_acc[VAL_W] ? '1 : sq_acc[VAL_W-1:0];
        end

        // Interval reset folds the sum into the base; clear drops both.
        if (cmd.interval_reset || cmd.clear_en)
        begin
            base_next       = cmd.clear_en ? '0 : (base_reg + isum_reg);
            isum_next       = '0;
            sq_sum_next     = '0;
            begin_next      = tick_now_reg;
            last_event_next = tick_now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now_reg   <= '0;
            begin_reg      <= '0;
            last_event_reg <= '0;
            base_reg       <= '0;
            isum_reg       <= '0;
            sq_sum_reg     <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
        end
        else
        begin
            tick_now_reg   <= tick_now_next;
            begin_reg      <= begin_next;
            last_event_reg <= last_event_next;
            base_reg       <= base_next;
            isum_reg       <= isum_next;
            sq_sum_reg     <= sq_sum_next;
            s1_vld_reg     <= event_hit;
            s2_vld_reg     <= s1_vld_reg && !cmd.clear_en;
        end
    end

    // Gap-square pipeline payload.
    always_ff @(posedge clk)
    begin
        if (event_hit)
        begin
            gap_lo_reg  <= gap_ext[SQ_HALF_W-1:0];
            gap_sat_reg <= |gap_ext[VAL_W-1:SQ_HALF_W];
        end
        if (s1_vld_reg)
        begin
            sq_reg <= gap_sat_reg ? '1 : sq_prod;
        end
    end

    // Sign and magnitude of the interval sum, and the two numerators.
    assign elapsed   = tick_now_reg - begin_reg;
    assign neg       = isum_reg[VAL_W-1];
    assign smag      = neg ? (-isum_reg) : isum_reg;
    assign rate_num  = NUM_W'(smag) << FRAC_BITS;
    assign rough_num = {acc_reg, 1'b0};
    assign div_num   = cmd.div_sel_rough ? rough_num : rate_num;

    erc_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (elapsed),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    // Saturate the quotient magnitude and apply the sign.
    always_comb
    begin
        lim         = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        mag_clamped = (div_ovf || (div_quo > lim)) ? lim : div_quo;
        enc         = neg ? (-mag_clamped) : mag_clamped;
    end

    // Partial products of the squared-gap sum by the rate magnitude.
    assign mul_a     = mul_idx_reg[0] ? sq_sum_reg[VAL_W-1:SQ_HALF_W] : sq_sum_reg[SQ_HALF_W-1:0];
    assign mul_b     = mul_idx_reg[1] ? rmag_reg[OUT_W-1:RM_HALF_W] : rmag_reg[RM_HALF_W-1:0];
    assign mul_p     = mul_a * mul_b;
    assign prod_ext  = ACC_W'(prod_reg);
    assign prod_sh_a = prod_idx_reg[0] ? (prod_ext << SQ_HALF_W) : prod_ext;
    assign prod_sh_b = prod_idx_reg[1] ? (prod_sh_a << RM_HALF_W) : prod_sh_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_run_reg  <= 1'b0;
            mul_idx_reg  <= '0;
            prod_vld_reg <= 1'b0;
            mul_done_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= mul_run_reg;
            mul_done_reg <= prod_vld_reg && (prod_idx_reg == MUL_IDX_W'(MUL_STEPS - 1));
            if (cmd.mul_start)
            begin
                mul_run_reg <= 1'b1;
                mul_idx_reg <= '0;
            end
            else if (mul_run_reg)
            begin
                mul_idx_reg <= mul_idx_reg + MUL_IDX_W'(1);
                if (mul_idx_reg == MUL_IDX_W'(MUL_STEPS - 1))
                begin
                    mul_run_reg <= 1'b0;
                end
            end
        end
    end

    // Result payload: products, accumulator, rate and roughness.
    always_ff @(posedge clk)
    begin
        if (mul_run_reg)
        begin
            prod_reg     <= mul_p;
            prod_idx_reg <= mul_idx_reg;
        end

        if (cmd.mul_start)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_sh_b;
        end

        if (cmd.res_zero)
        begin
            rate_reg  <= '0;
            rough_reg <= '0;
        end
        if (cmd.rate_load)
        begin
            rmag_reg <= mag_clamped;
            rate_reg <= enc;
        end
        if (cmd.rough_load)
        begin
            rough_reg <= enc;
        end

        if (cmd.out_load)
        begin
            total_out_reg <= base_reg + isum_reg;
            rate_out_reg  <= rate_reg;
            rough_out_reg <= rough_reg;
        end
    end

    assign status.sq_busy      = s1_vld_reg || s2_vld_reg;
    assign status.elapsed_zero = (elapsed == '0);
    assign status.div_done     = div_done;
    assign status.div_busy     = div_busy;
    assign status.mul_done     = mul_done_reg;

    assign total_value   = total_out_reg;
    assign rate_q16      = rate_out_reg;
    assign roughness_q16 = rough_out_reg;

    // A result must never be taken while a gap square is still in flight.
    a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(s1_vld_reg || s2_vld_reg))
        else $error("result loaded with squared-gap pipeline busy");

    // Clear empties the squared-gap sum even with squares in flight.
    a_clear_empties_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |=> (sq_sum_reg == '0))
        else $error("squared-gap sum not empty after clear");

endmodule

// ===== rtl/core/erc_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// erc_ctrl: controller of the event rate and roughness counter
// Accepts input words, issues single-cycle commands for ticks, events and
// clears, and sequences the divisions and multiplication of a read.
// ============================================================================

module erc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [erc_pkg::FUNC_W-1:0]    func,
    output logic                          out_valid,
    input  logic                          out_ready,
    output erc_pkg::dp_cmd_t              cmd,
    input  erc_pkg::dp_status_t           status
);
    import erc_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        read_reset_reg, read_reset_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next      = state_reg;
        read_reset_next = read_reset_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && ((func == FUNC_READ) || (func == FUNC_READ_RESET)))
                begin
                    state_next      = ST_DRAIN;
                    read_reset_next = (func == FUNC_READ_RESET);
                end
            end
            ST_DRAIN:
            begin
                if (!status.sq_busy)
                begin
                    state_next = status.elapsed_zero ? ST_LOAD : ST_RATE_DIV;
                end
            end
            ST_RATE_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.mul_done)
                begin
                    state_next = ST_ROUGH_DIV;
                end
            end
            ST_ROUGH_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (func)
                        FUNC_TICK:  cmd.tick_en  = 1'b1;
                        FUNC_EVENT: cmd.event_en = 1'b1;
                        FUNC_CLEAR: cmd.clear_en = 1'b1;
                        default:    cmd          = '0;
                    endcase
                end
            end
            ST_DRAIN:
            begin
                if (!status.sq_busy)
                begin
                    cmd.res_zero  = status.elapsed_zero;
                    cmd.div_start = !status.elapsed_zero;
                end
            end
            ST_RATE_DIV:
            begin
                cmd.rate_load = status.div_done;
            end
            ST_MUL_GO:
            begin
                cmd.mul_start = 1'b1;
            end
            ST_MUL:
            begin
                cmd.div_start     = status.mul_done;
                cmd.div_sel_rough = 1'b1;
            end
            ST_ROUGH_DIV:
            begin
                cmd.rough_load = status.div_done;
            end
            ST_LOAD:
            begin
                cmd.out_load       = out_free;
                cmd.interval_reset = out_free && read_reset_reg;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // The output register holds its word until the receiver takes it.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            read_reset_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_reset_reg <= read_reset_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result word overwritten before it was taken");

    // The shared divider is started only when it is idle.
    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

endmodule

// ===== rtl/core/event_rate_roughness_counter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// event_rate_roughness_counter: event statistics with rate and roughness
// Input words carry an operation and a signed delta: tick, event, read,
// read then reset interval, or clear. A read returns one result word with
// the total value, the Q16 rate and the Q16 roughness.
//
// Ticks, events, clears and unused codes are taken one word every cycle
// while no read is in progress, and give no result. A read holds the input
// until its result is loaded: the gap-square pipeline drains, then two
// radix-2 divisions in the shared divider run around a partial-product
// multiplication, and the result is loaded into the output register. A
// division whose quotient must saturate ends at once. A read with no
// elapsed ticks skips the divisions and the multiplication and returns
// a zero rate and roughness.
// Reset clears the tick clock, all sums and any pending result.
// A finished result waits in the output register while further ticks and
// events are accepted; a later read holds in its last step until that
// register has been emptied.
// ============================================================================

module event_rate_roughness_counter #(
    parameter int TIME_BITS = erc_pkg::TIME_BITS_DEF,
    parameter int FRAC_BITS = erc_pkg::FRAC_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    erc_in_if.sink    items,
    erc_out_if.source results
);
    import erc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller: handshakes and read sequencing.
    erc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .in_ready  (items.ready),
        .func      (items.func),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Datapath: counters, sums and arithmetic.
    erc_dp #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .delta         (items.delta),
        .total_value   (results.total_value),
        .rate_q16      (results.rate_q16),
        .roughness_q16 (results.roughness_q16)
    );

endmodule
